@@ hw/rtl/gd3tfe_pkg.sv @@
// Shared types and constants for the GD3 tag field extractor.
package gd3tfe_pkg;

  localparam int FIELD_COUNT_DEF = 11;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int MAX_RESULTS     = 15;
  localparam int FIELD_W         = 4;

  localparam logic [31:0] MAGIC_WORD  = 32'h2033_6447;  // "Gd3 " little-endian
  localparam logic [31:0] OFFSET_POS  = 32'h0000_0014;
  localparam logic [15:0] ONE_BYTE_LIM = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIM = 16'h0800;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_FEND  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_NOTAG = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       file_end;
  } in_word_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] field_number;
    logic [7:0]         text_byte;
    logic [31:0]        tag_version;
    logic [31:0]        tag_length;
    logic               run_end;
  } out_word_t;

  // One queue entry: everything a single input byte asks the back end to emit.
  typedef struct packed {
    logic               unit_en;
    logic [15:0]        unit_w;
    logic [FIELD_W-1:0] unit_field;
    logic               ends_en;
    logic [FIELD_W-1:0] ends_first;
    logic [FIELD_W-1:0] ends_last;
    logic               fin_en;
    logic               fin_notag;
    logic [31:0]        ver;
    logic [31:0]        len;
  } cmd_t;

endpackage

@@ hw/rtl/gd3tfe_front.sv @@
// Front end: byte parser that tracks the file layout and queues emit commands.
module gd3tfe_front #(
  parameter int FIELD_COUNT = gd3tfe_pkg::FIELD_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  gd3tfe_pkg::in_word_t in_word,
  output logic                 cmd_push,
  output gd3tfe_pkg::cmd_t     cmd
);
  import gd3tfe_pkg::*;

  localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(FIELD_COUNT - 1);
  localparam logic [FIELD_W-1:0] FIELD_LIM  = FIELD_W'(FIELD_COUNT);

  typedef enum logic [2:0] {
    P_SEEK, P_SKIP, P_HEADER, P_DATA, P_DONE
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [31:0]        pos_r, pos_nxt;
  logic [32:0]        ts_r, ts_nxt;
  logic [31:0]        gather_r, gather_nxt;
  logic [31:0]        ver_r, ver_nxt;
  logic [31:0]        len_r, len_nxt;
  logic [31:0]        dcnt_r, dcnt_nxt;
  logic [FIELD_W-1:0] cf_r, cf_nxt;
  logic [7:0]         low_r, low_nxt;
  cmd_t               cmd_c;

  always_comb begin
    logic        hdr_en;
    logic [3:0]  hdr_idx;
    logic        gat_en;
    logic [1:0]  gat_idx;
    logic [7:0]  b;
    logic [15:0] w;
    hdr_en     = 1'b0;
    hdr_idx    = '0;
    gat_en     = 1'b0;
    gat_idx    = '0;
    b          = in_word.file_byte;
    w          = {b, low_r};
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    ts_nxt     = ts_r;
    gather_nxt = gather_r;
    ver_nxt    = ver_r;
    len_nxt    = len_r;
    dcnt_nxt   = dcnt_r;
    cf_nxt     = cf_r;
    low_nxt    = low_r;
    cmd_c      = '0;

    if (accept) begin
      unique case (phase_r)
        P_SEEK: begin
          if (pos_r[31:2] == OFFSET_POS[31:2]) begin
            gat_en  = 1'b1;
            gat_idx = pos_r[1:0];
          end
        end
        P_SKIP: begin
          if ({1'b0, pos_r} == ts_r) begin
            phase_nxt = P_HEADER;
            hdr_en    = 1'b1;
            hdr_idx   = '0;
          end
        end
        P_HEADER: begin
          hdr_en  = 1'b1;
          hdr_idx = pos_r[3:0] - ts_r[3:0];
        end
        P_DATA: begin
          if (!dcnt_r[0]) begin
            low_nxt = b;
          end else if (w == 16'h0000) begin
            cmd_c.ends_en    = 1'b1;
            cmd_c.ends_first = cf_r;
            cmd_c.ends_last  = cf_r;
            cf_nxt           = cf_r + 1'b1;
            if (cf_nxt >= FIELD_LIM) begin
              cmd_c.fin_en = 1'b1;
              phase_nxt    = P_DONE;
            end
          end else begin
            cmd_c.unit_en    = 1'b1;
            cmd_c.unit_w     = w;
            cmd_c.unit_field = cf_r;
          end
          dcnt_nxt = dcnt_r + 32'd1;
          if (phase_nxt == P_DATA && dcnt_nxt == len_r) begin
            if (!cmd_c.ends_en) cmd_c.ends_first = cf_nxt;
            cmd_c.ends_en   = 1'b1;
            cmd_c.ends_last = LAST_FIELD;
            cmd_c.fin_en    = 1'b1;
            phase_nxt       = P_DONE;
          end
        end
        P_DONE: begin
        end
        default: begin
        end
      endcase

      if (hdr_en) begin
        gat_en  = 1'b1;
        gat_idx = hdr_idx[1:0];
      end
      if (gat_en) begin
        if (gat_idx == 2'd0) gather_nxt = {24'h0, b};
        else gather_nxt = gather_r | ({24'h0, b} << {gat_idx, 3'b000});
      end

      // offset word complete
      if (phase_r == P_SEEK && gat_en && gat_idx == 2'd3) begin
        if (gather_nxt < 32'd4) begin
          cmd_c.fin_en    = 1'b1;
          cmd_c.fin_notag = 1'b1;
          phase_nxt       = P_DONE;
        end else begin
          ts_nxt    = {1'b0, OFFSET_POS} + {1'b0, gather_nxt};
          phase_nxt = P_SKIP;
        end
      end

      if (hdr_en) begin
        if (hdr_idx == 4'd3) begin
          if (gather_nxt != MAGIC_WORD) begin
            cmd_c.fin_en    = 1'b1;
            cmd_c.fin_notag = 1'b1;
            phase_nxt       = P_DONE;
          end
        end else if (hdr_idx == 4'd7) begin
          ver_nxt = gather_nxt;
        end else if (hdr_idx == 4'd11) begin
          len_nxt   = gather_nxt;
          phase_nxt = P_DATA;
          dcnt_nxt  = '0;
          cf_nxt    = '0;
          if (gather_nxt == 32'd0) begin
            cmd_c.ends_en    = 1'b1;
            cmd_c.ends_first = '0;
            cmd_c.ends_last  = LAST_FIELD;
            cmd_c.fin_en     = 1'b1;
            phase_nxt        = P_DONE;
          end
        end
      end

      if (pos_r != 32'hFFFF_FFFF) pos_nxt = pos_r + 32'd1;

      if (in_word.file_end) begin
        if (phase_nxt == P_SEEK || phase_nxt == P_SKIP || phase_nxt == P_HEADER) begin
          cmd_c.fin_en    = 1'b1;
          cmd_c.fin_notag = 1'b1;
        end else if (phase_nxt == P_DATA) begin
          if (!cmd_c.ends_en) cmd_c.ends_first = cf_nxt;
          cmd_c.ends_en   = 1'b1;
          cmd_c.ends_last = LAST_FIELD;
          cmd_c.fin_en    = 1'b1;
        end
      end

      cmd_c.ver = ver_nxt;
      cmd_c.len = len_nxt;

      // file end: back to the reset state for the next file
      if (in_word.file_end) begin
        phase_nxt  = P_SEEK;
        pos_nxt    = '0;
        ts_nxt     = '0;
        gather_nxt = '0;
        ver_nxt    = '0;
        len_nxt    = '0;
        dcnt_nxt   = '0;
        cf_nxt     = '0;
        low_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= P_SEEK;
      pos_r    <= '0;
      ts_r     <= '0;
      gather_r <= '0;
      ver_r    <= '0;
      len_r    <= '0;
      dcnt_r   <= '0;
      cf_r     <= '0;
      low_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      ts_r     <= ts_nxt;
      gather_r <= gather_nxt;
      ver_r    <= ver_nxt;
      len_r    <= len_nxt;
      dcnt_r   <= dcnt_nxt;
      cf_r     <= cf_nxt;
      low_r    <= low_nxt;
    end
  end

  assign cmd      = cmd_c;
  assign cmd_push = accept && (cmd_c.unit_en || cmd_c.ends_en || cmd_c.fin_en);

  a_data_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == P_DATA |-> cf_r < FIELD_LIM)
    else $error("data phase with field index past the last field");
  a_ends_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push && cmd_c.ends_en |-> cmd_c.ends_first <= cmd_c.ends_last)
    else $error("field end range reversed");
  a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push && cmd_c.unit_en |-> cmd_c.unit_w != 16'h0000 && !cmd_c.fin_notag)
    else $error("text unit queued with a null code unit or no-tag flag");

endmodule

@@ hw/rtl/gd3tfe_queue.sv @@
// Short command queue between parser and emitter.
module gd3tfe_queue #(
  parameter int DEPTH = gd3tfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gd3tfe_pkg::cmd_t push_data,
  output logic             full,
  input  logic             pop,
  output gd3tfe_pkg::cmd_t head,
  output logic             empty
);
  import gd3tfe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + 1'b1;
    if (do_pop) rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count past depth");
  a_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("command pushed into a full queue");
  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

@@ hw/rtl/gd3tfe_back.sv @@
// Back end: expands queued commands into result words, one per cycle unless stalled.
module gd3tfe_back #(
  parameter int FIELD_COUNT = gd3tfe_pkg::FIELD_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gd3tfe_pkg::cmd_t      head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output gd3tfe_pkg::out_word_t out_word
);
  import gd3tfe_pkg::*;

  localparam logic [FIELD_W-1:0] FIELD_LIM = FIELD_W'(FIELD_COUNT);
  localparam logic [3:0]         CNT_LAST  = 4'(MAX_RESULTS - 1);

  typedef enum logic [1:0] {S_START, S_UNIT, S_ENDS, S_FIN} step_t;

  step_t              step_r, step_nxt;
  logic [1:0]         ub_r, ub_nxt;
  logic [FIELD_W-1:0] fld_r, fld_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic               ovalid_r;
  out_word_t          out_r;
  out_word_t          res;
  logic               fire;

  function automatic logic [7:0] utf8_byte(input logic [15:0] w, input logic [1:0] nb,
                                           input logic [1:0] ub);
    logic [7:0] r;
    r = w[7:0];
    if (nb == 2'd2) begin
      r = (ub == 2'd0) ? {3'b110, w[10:6]} : {2'b10, w[5:0]};
    end else if (nb == 2'd3) begin
      case (ub)
        2'd0:    r = {4'b1110, w[15:12]};
        2'd1:    r = {2'b10, w[11:6]};
        default: r = {2'b10, w[5:0]};
      endcase
    end
    return r;
  endfunction

  assign fire  = !q_empty && (!ovalid_r || pop);
  assign empty = !ovalid_r;

  always_comb begin
    step_t              eff;
    logic [1:0]         ub;
    logic [FIELD_W-1:0] fld;
    logic [1:0]         nb;
    logic               ent_done;
    if (step_r == S_START) begin
      eff = head.unit_en ? S_UNIT : (head.ends_en ? S_ENDS : S_FIN);
      ub  = '0;
      fld = head.ends_first;
    end else begin
      eff = step_r;
      ub  = ub_r;
      fld = fld_r;
    end
    if (head.unit_w < ONE_BYTE_LIM) nb = 2'd1;
    else if (head.unit_w < TWO_BYTE_LIM) nb = 2'd2;
    else nb = 2'd3;

    res      = '0;
    step_nxt = eff;
    ub_nxt   = ub;
    fld_nxt  = fld;
    ent_done = 1'b0;

    unique case (eff)
      S_UNIT: begin
        res.kind         = KIND_TEXT;
        res.field_number = head.unit_field;
        res.text_byte    = utf8_byte(head.unit_w, nb, ub);
        res.tag_version  = head.ver;
        res.tag_length   = head.len;
        if (ub != nb - 2'd1) begin
          ub_nxt = ub + 2'd1;
        end else if (head.ends_en) begin
          step_nxt = S_ENDS;
          fld_nxt  = head.ends_first;
        end else if (head.fin_en) begin
          step_nxt = S_FIN;
        end else begin
          ent_done = 1'b1;
        end
      end
      S_ENDS: begin
        res.kind         = KIND_FEND;
        res.field_number = fld;
        res.tag_version  = head.ver;
        res.tag_length   = head.len;
        if (fld != head.ends_last) fld_nxt = fld + 1'b1;
        else if (head.fin_en) step_nxt = S_FIN;
        else ent_done = 1'b1;
      end
      default: begin
        ent_done = 1'b1;
        if (head.fin_notag) begin
          res.kind = KIND_NOTAG;
        end else begin
          res.kind        = KIND_DONE;
          res.tag_version = head.ver;
          res.tag_length  = head.len;
        end
      end
    endcase

    // result cap per input byte: drop whatever follows the last allowed word
    res.run_end = ent_done || (cnt_r == CNT_LAST);
    q_pop       = fire && res.run_end;
    cnt_nxt     = cnt_r + 4'd1;
    if (res.run_end) begin
      step_nxt = S_START;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= S_START;
      ub_r     <= '0;
      fld_r    <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
      out_r    <= '0;
    end else begin
      if (fire) begin
        step_r   <= step_nxt;
        ub_r     <= ub_nxt;
        fld_r    <= fld_nxt;
        cnt_r    <= cnt_nxt;
        ovalid_r <= 1'b1;
        out_r    <= res;
      end else if (pop) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_word = out_r;

  a_notag_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && out_r.kind == KIND_NOTAG |->
      out_r.tag_version == 32'd0 && out_r.tag_length == 32'd0 && out_r.run_end)
    else $error("no-tag word carries header data or is not the last word");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && out_r.kind == KIND_DONE |-> out_r.run_end && out_r.field_number == '0)
    else $error("tag finished word not closing its run");
  a_text_field: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && (out_r.kind == KIND_TEXT || out_r.kind == KIND_FEND) |->
      out_r.field_number < FIELD_LIM)
    else $error("field number past the last field");
  a_text_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && out_r.kind != KIND_TEXT |-> out_r.text_byte == 8'h00)
    else $error("text byte set on a non-text word");

endmodule

@@ hw/rtl/gd3_tag_field_extractor.sv @@
// Top level of the GD3 tag field extractor: parser, command queue, emitter.
// A byte's command is queued, then its result words are registered in the emitter output.
// Throughput: one byte per cycle while the command queue has room; the emitter puts out
//   one result word per cycle unless stalled; a code unit (two bytes) gives 1-3 words.
// Reset: synchronous, active low; clears parser state, queue pointers and output valid.
// No memory clearing pass; the block accepts bytes the cycle after reset drops.
module gd3_tag_field_extractor #(
  parameter int FIELD_COUNT = gd3tfe_pkg::FIELD_COUNT_DEF,
  parameter int QUEUE_DEPTH = gd3tfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  gd3tfe_pkg::in_word_t  in_word,
  output logic                  empty,
  input  logic                  pop,
  output gd3tfe_pkg::out_word_t out_word
);
  import gd3tfe_pkg::*;

  logic accept;
  logic cmd_push;
  cmd_t cmd;
  cmd_t head;
  logic q_full, q_empty, q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  gd3tfe_front #(
    .FIELD_COUNT(FIELD_COUNT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_word),
    .cmd_push(cmd_push),
    .cmd     (cmd)
  );

  gd3tfe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  gd3tfe_back #(
    .FIELD_COUNT(FIELD_COUNT)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_word(out_word)
  );

endmodule
